### hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/cpma_pkg.sv
// shared constants and helpers for the clamped position moving average
`timescale 1ns / 1ps
`default_nettype none

package cpma_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int ACT_W          = 2;
    localparam int SAMPLE_W       = 18;
    localparam int COORD_W        = 17;
    localparam int WIN_W          = 6;
    localparam int IN_TDATA_W     = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int ONE_Q16        = 65536;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 6'd10;

    localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

    // clamp a signed q1.16 coordinate to 0..1
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [SAMPLE_W-1:0] raw);
        logic [COORD_W-1:0] res;
        if (raw[SAMPLE_W-1]) begin
            res = '0;
        end else if (raw[COORD_W-1] && (|raw[COORD_W-2:0])) begin
            res = COORD_W'(ONE_Q16);
        end else begin
            res = raw[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/cpma_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module cpma_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/clamped_position_moving_average.sv
// top level of the clamped position moving average
`timescale 1ns / 1ps
`default_nettype none

// Takes 2D position samples (signed q1.16), clamps each coordinate to 0..1 and keeps
// them in a ring of RING_DEPTH entries. Per transaction the tuser action picks push,
// replace newest, or clear (code 3 leaves the history alone), and exactly one result
// comes back: truncated mean x, mean y (unsigned q1.16, zero when empty) and the held
// count. A push drops the oldest sample first once more than window_len samples are
// held or the ring is full, so up to window_len+1 samples are averaged. Each item goes
// through accept, ring read and running-sum update (states RD, SUB, ADD), divider load,
// then a bit-serial restoring divider that shifts out one quotient bit per cycle over
// the SUM_W-bit sums, x and y side by side, and the hand-off into the output register.
// No new item is taken before the last one's result sits in the output register, but
// it is taken then, even before the sink takes the result. The user must see that
// window_len is written over the cfg port only while idle; the block itself does not
// enforce it. window_len resets to 10. The ring needs no clearing after reset.
module clamped_position_moving_average #(
    parameter int RING_DEPTH = cpma_pkg::RING_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // sample_x [17:0], sample_y [35:18], zero pad above
    input  wire logic [cpma_pkg::IN_TDATA_W-1:0] s_tdata,
    // action [1:0]
    input  wire logic [cpma_pkg::ACT_W-1:0]      s_tuser,

    output logic                                                          m_tvalid,
    input  wire logic                                                     m_tready,
    // mean_x [16:0], mean_y [33:17], held_count above, zero pad to bytes
    output logic [((2*cpma_pkg::COORD_W+$clog2(RING_DEPTH+1)+7)/8)*8-1:0] m_tdata,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [cpma_pkg::WIN_W-1:0] cfg_data
);

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = $clog2(cpma_pkg::ONE_Q16 * RING_DEPTH + 1);
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int CMP_W   = (CNT_W > cpma_pkg::WIN_W) ? CNT_W : cpma_pkg::WIN_W;
    localparam int C_W     = cpma_pkg::COORD_W;
    localparam int TDATA_W = ((2 * C_W + CNT_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - 2 * C_W - CNT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
    localparam logic [2:0] ST_RD   = 3'd1;  // ring read issued
    localparam logic [2:0] ST_SUB  = 3'd2;  // remove dropped or replaced sample from sums
    localparam logic [2:0] ST_ADD  = 3'd3;  // write ring, add new sample, move pointers, or clear
    localparam logic [2:0] ST_LOAD = 3'd4;  // load the divider
    localparam logic [2:0] ST_DIV  = 3'd5;  // one quotient bit per cycle
    localparam logic [2:0] ST_DONE = 3'd6;  // hand result to output register

    // control state
    logic [2:0]               state_reg, state_next;
    logic [cpma_pkg::WIN_W-1:0] win_reg, win_next;
    logic [PTR_W-1:0]         oldest_reg, oldest_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]         sumx_reg, sumx_next;
    logic [SUM_W-1:0]         sumy_reg, sumy_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     mvalid_reg, mvalid_next;

    // payload
    logic [cpma_pkg::ACT_W-1:0] act_reg, act_next;
    logic [C_W-1:0]             x_reg, x_next;
    logic [C_W-1:0]             y_reg, y_next;
    logic [SUM_W-1:0]           dvx_reg, dvx_next;
    logic [SUM_W-1:0]           dvy_reg, dvy_next;
    logic [CNT_W-1:0]           remx_reg, remx_next;
    logic [CNT_W-1:0]           remy_reg, remy_next;
    logic [C_W-1:0]             meanx_reg, meanx_next;
    logic [C_W-1:0]             meany_reg, meany_next;
    logic [CNT_W-1:0]           hcnt_reg, hcnt_next;

    // decoded action against the current history
    logic op_push, op_repl, op_clear, drop;

    // ring slot math
    logic [CNT_W-1:0] slot_off;
    logic [CNT_W:0]   slot_pos, slot_wrap;
    logic [PTR_W-1:0] slot, oldest_inc;

    // ring port
    logic             ram_we, ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [2*C_W-1:0] ram_rdata;
    logic [C_W-1:0]   rd_x, rd_y;

    // divider step
    logic [CNT_W:0] trial_x, trial_y, div_by;
    logic           ge_x, ge_y;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, hcnt_reg, meany_reg, meanx_reg};

    assign rd_x = ram_rdata[C_W-1:0];
    assign rd_y = ram_rdata[2*C_W-1:C_W];

    // replace on an empty history acts as a push
    always_comb begin
        op_push  = (act_reg == cpma_pkg::ACT_PUSH) ||
                   ((act_reg == cpma_pkg::ACT_REPLACE) && (cnt_reg == '0));
        op_repl  = (act_reg == cpma_pkg::ACT_REPLACE) && (cnt_reg != '0);
        op_clear = (act_reg == cpma_pkg::ACT_CLEAR);
        drop     = op_push && (cnt_reg != '0) &&
                   ((CMP_W'(cnt_reg) > CMP_W'(win_reg)) ||
                    (cnt_reg >= CNT_W'(RING_DEPTH)));
    end

    // push writes at oldest+count, replace at oldest+count-1, both wrapped once
    always_comb begin
        slot_off   = op_repl ? (cnt_reg - 1'b1) : cnt_reg;
        slot_pos   = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(slot_off);
        slot_wrap  = (slot_pos >= (CNT_W+1)'(RING_DEPTH)) ?
                     (slot_pos - (CNT_W+1)'(RING_DEPTH)) : slot_pos;
        slot       = slot_wrap[PTR_W-1:0];
        oldest_inc = (oldest_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : (oldest_reg + 1'b1);
        ram_raddr  = op_repl ? slot : oldest_reg;
        ram_re     = (state_reg == ST_RD);
        ram_we     = (state_reg == ST_ADD) && (op_push || op_repl);
    end

    always_comb begin
        div_by  = {1'b0, cnt_reg};
        trial_x = {remx_reg, dvx_reg[SUM_W-1]};
        trial_y = {remy_reg, dvy_reg[SUM_W-1]};
        ge_x    = (trial_x >= div_by);
        ge_y    = (trial_y >= div_by);
    end

    always_comb begin
        state_next  = state_reg;
        win_next    = win_reg;
        oldest_next = oldest_reg;
        cnt_next    = cnt_reg;
        sumx_next   = sumx_reg;
        sumy_next   = sumy_reg;
        step_next   = step_reg;
        mvalid_next = mvalid_reg && !m_tready;
        act_next    = act_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dvx_next    = dvx_reg;
        dvy_next    = dvy_reg;
        remx_next   = remx_reg;
        remy_next   = remy_reg;
        meanx_next  = meanx_reg;
        meany_next  = meany_reg;
        hcnt_next   = hcnt_reg;

        if (cfg_valid) begin
            win_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    x_next     = cpma_pkg::clamp_coord(s_tdata[cpma_pkg::SAMPLE_W-1:0]);
                    y_next     = cpma_pkg::clamp_coord(
                                     s_tdata[2*cpma_pkg::SAMPLE_W-1:cpma_pkg::SAMPLE_W]);
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                if (drop || op_repl) begin
                    sumx_next = sumx_reg - SUM_W'(rd_x);
                    sumy_next = sumy_reg - SUM_W'(rd_y);
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (op_clear) begin
                    cnt_next    = '0;
                    oldest_next = '0;
                    sumx_next   = '0;
                    sumy_next   = '0;
                end else if (op_push || op_repl) begin
                    sumx_next = sumx_reg + SUM_W'(x_reg);
                    sumy_next = sumy_reg + SUM_W'(y_reg);
                    if (op_push && !drop) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (drop) begin
                        oldest_next = oldest_inc;
                    end
                end
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                dvx_next   = sumx_reg;
                dvy_next   = sumy_reg;
                remx_next  = '0;
                remy_next  = '0;
                step_next  = STEP_W'(SUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                remx_next = ge_x ? CNT_W'(trial_x - div_by) : trial_x[CNT_W-1:0];
                remy_next = ge_y ? CNT_W'(trial_y - div_by) : trial_y[CNT_W-1:0];
                dvx_next  = {dvx_reg[SUM_W-2:0], ge_x};
                dvy_next  = {dvy_reg[SUM_W-2:0], ge_y};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // empty history reports zero means
                if (!mvalid_reg || m_tready) begin
                    meanx_next  = (cnt_reg == '0) ? '0 : dvx_reg[C_W-1:0];
                    meany_next  = (cnt_reg == '0) ? '0 : dvy_reg[C_W-1:0];
                    hcnt_next   = cnt_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            win_reg    <= cpma_pkg::WINDOW_LEN_RST;
            oldest_reg <= '0;
            cnt_reg    <= '0;
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            oldest_reg <= oldest_next;
            cnt_reg    <= cnt_next;
            sumx_reg   <= sumx_next;
            sumy_reg   <= sumy_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        dvx_reg   <= dvx_next;
        dvy_reg   <= dvy_next;
        remx_reg  <= remx_next;
        remy_reg  <= remy_next;
        meanx_reg <= meanx_next;
        meany_reg <= meany_next;
        hcnt_reg  <= hcnt_next;
    end

    // sample ring, y in the upper half
    cpma_ram #(
        .WIDTH(2 * C_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(slot),
        .wdata({y_reg, x_reg}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

`default_nettype wire

### hdl/cpma_checker.sv
// port-level checker for the clamped position moving average, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cpma_checker #(
    parameter int RING_DEPTH = cpma_pkg::RING_DEPTH_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((2*cpma_pkg::COORD_W+$clog2(RING_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int C_W   = cpma_pkg::COORD_W;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    logic [C_W-1:0]   mean_x, mean_y;
    logic [CNT_W-1:0] held;

    assign mean_x = m_tdata[C_W-1:0];
    assign mean_y = m_tdata[2*C_W-1:C_W];
    assign held   = m_tdata[2*C_W+CNT_W-1:2*C_W];

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // count never passes the ring depth
    `ASSERT_IMPLY(a_cnt_max, aclk, aresetn, m_tvalid, held <= CNT_W'(RING_DEPTH))

    // empty history means zero means
    `ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_tvalid && (held == '0), (mean_x == '0) && (mean_y == '0))

    // clamped samples keep the means within one
    `ASSERT_IMPLY(a_mean_range, aclk, aresetn, m_tvalid, (mean_x <= C_W'(cpma_pkg::ONE_Q16)) && (mean_y <= C_W'(cpma_pkg::ONE_Q16)))

endmodule

bind clamped_position_moving_average cpma_checker #(
    .RING_DEPTH(RING_DEPTH)
) u_cpma_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
